// ----- hdl/rhc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants of the RGB to HSV converter
// Widths of the long-division pipeline and the hue sector code.
// ----------------------------------------------------------------------------
package rhc_pkg;

    // Quotient bits per divide: 12 hue bits, saturation taken from the top 8
    localparam int unsigned DIV_QW = 12;
    // Divisor bits: 6*delta reaches 1530
    localparam int unsigned DIV_DW = 11;
    // Cycles from an accepted start to the done strobe
    localparam int unsigned LATENCY = DIV_QW + 3;
    // Fraction bits kept below the saturation result
    localparam int unsigned SAT_FRAC = 4;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

endpackage

// ----- hdl/rgb_to_hsv_converter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core: RGB pixel to hue / saturation / value
// Max/min and sector pick, operand build, then two 12-stage dividers.
//
//   channel  | ports                       | handshake
//   ---------+-----------------------------+------------------------------
//   pixel in | red, green, blue            | start, transfer when !busy
//   result   | hue, saturation, value      | done, one-cycle strobe
//
// A pixel is taken every cycle; busy stays low, the pipeline never stalls.
// Each result passes through one stage for max/min, one for operands,
// 12 for the bit-per-stage dividers and one output register.
// Reset clears the valid bits only; the receiver cannot hold results off.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        done,
    output logic [11:0] hue,
    output logic [7:0]  saturation,
    output logic [7:0]  value
);

    localparam int unsigned QW = rhc_pkg::DIV_QW;
    localparam int unsigned DW = rhc_pkg::DIV_DW;

    // ---------------- stage 1: max, min, sector ----------------
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [7:0]       s1_hi_reg, s1_hi_next;
    logic [7:0]       s1_lo_reg, s1_lo_next;
    logic [8:0]       s1_diff_reg, s1_diff_next;
    rhc_pkg::sector_t s1_sect_reg, s1_sect_next;

    assign busy          = 1'b0;
    assign s1_valid_next = start && !busy;

    always_comb
    begin
        if (red >= green && red >= blue) begin
            s1_sect_next = rhc_pkg::SECT_RED;
            s1_hi_next   = red;
            s1_diff_next = {1'b0, green} - {1'b0, blue};
        end else if (green >= blue) begin
            s1_sect_next = rhc_pkg::SECT_GREEN;
            s1_hi_next   = green;
            s1_diff_next = {1'b0, blue} - {1'b0, red};
        end else begin
            s1_sect_next = rhc_pkg::SECT_BLUE;
            s1_hi_next   = blue;
            s1_diff_next = {1'b0, red} - {1'b0, green};
        end
        s1_lo_next = red;
        if (green < s1_lo_next) begin
            s1_lo_next = green;
        end
        if (blue < s1_lo_next) begin
            s1_lo_next = blue;
        end
    end

    // ---------------- stage 2: divider operands ----------------
    logic             s2_valid_reg;
    logic [7:0]       delta;
    logic [11:0]      delta_w;
    logic [11:0]      base;
    logic [11:0]      sixths;
    logic [11:0]      delta6;
    logic [15:0]      nsat;
    logic [7:0]       s2_value_reg;
    logic             s2_gray_reg;
    logic [DW-1:0]    hue_rem_reg, hue_rem_next;
    logic [DW-1:0]    hue_div_reg, hue_div_next;
    logic [DW-1:0]    sat_rem_reg, sat_rem_next;
    logic [DW-1:0]    sat_div_reg, sat_div_next;
    logic [QW-1:0]    sat_low_reg, sat_low_next;

    assign delta   = s1_hi_reg - s1_lo_reg;
    assign delta_w = {4'b0, delta};
    assign delta6  = (delta_w << 2) + (delta_w << 1);

    always_comb
    begin
        case (s1_sect_reg)
            rhc_pkg::SECT_GREEN: base = delta_w << 1;
            rhc_pkg::SECT_BLUE:  base = delta_w << 2;
            // red: wrap a negative G-B by a full turn
            default:             base = s1_diff_reg[8] ? delta6 : '0;
        endcase
    end

    assign sixths = base + {{3{s1_diff_reg[8]}}, s1_diff_reg};
    // 255*delta, split into a starting remainder and shifted-in bits
    assign nsat   = {delta, 8'b0} - {8'b0, delta};

    assign hue_rem_next = sixths[DW-1:0];
    assign hue_div_next = delta6[DW-1:0];
    assign sat_rem_next = {{(DW-8){1'b0}}, nsat[15:8]};
    assign sat_div_next = {{(DW-8){1'b0}}, s1_hi_reg};
    assign sat_low_next = {nsat[7:0], {rhc_pkg::SAT_FRAC{1'b0}}};

    always_ff @(posedge clk)
    begin
        s1_hi_reg    <= s1_hi_next;
        s1_lo_reg    <= s1_lo_next;
        s1_diff_reg  <= s1_diff_next;
        s1_sect_reg  <= s1_sect_next;
        hue_rem_reg  <= hue_rem_next;
        hue_div_reg  <= hue_div_next;
        sat_rem_reg  <= sat_rem_next;
        sat_div_reg  <= sat_div_next;
        sat_low_reg  <= sat_low_next;
        s2_value_reg <= s1_hi_reg;
        s2_gray_reg  <= (delta == 8'd0);
    end

    // ---------------- stages 3..14: dividers ----------------
    logic [QW-1:0] hue_q;
    logic [QW-1:0] sat_q;

    rhc_div_pipe #(
        .QW (QW),
        .DW (DW)
    ) u_hue_div (
        .clk      (clk),
        .rem_init (hue_rem_reg),
        .low      ({QW{1'b0}}),
        .divisor  (hue_div_reg),
        .quotient (hue_q)
    );

    rhc_div_pipe #(
        .QW (QW),
        .DW (DW)
    ) u_sat_div (
        .clk      (clk),
        .rem_init (sat_rem_reg),
        .low      (sat_low_reg),
        .divisor  (sat_div_reg),
        .quotient (sat_q)
    );

    // side data travels alongside the divider stages
    logic       vline_reg [QW];
    logic [7:0] value_line_reg [QW];
    logic       gray_line_reg [QW];

    always_ff @(posedge clk)
    begin
        value_line_reg[0] <= s2_value_reg;
        gray_line_reg[0]  <= s2_gray_reg;
        for (int i = 1; i < QW; i++) begin
            value_line_reg[i] <= value_line_reg[i-1];
            gray_line_reg[i]  <= gray_line_reg[i-1];
        end
    end

    // ---------------- output register ----------------
    logic        done_reg;
    logic [11:0] hue_reg;
    logic [7:0]  sat_reg;
    logic [7:0]  value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int i = 0; i < QW; i++) begin
                vline_reg[i] <= 1'b0;
            end
            done_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            vline_reg[0] <= s2_valid_reg;
            for (int i = 1; i < QW; i++) begin
                vline_reg[i] <= vline_reg[i-1];
            end
            done_reg <= vline_reg[QW-1];
        end
    end

    // gray pixels leave a zero divisor: force hue and saturation to zero
    always_ff @(posedge clk)
    begin
        hue_reg   <= gray_line_reg[QW-1] ? 12'd0 : hue_q;
        sat_reg   <= gray_line_reg[QW-1] ? 8'd0 : sat_q[QW-1 -: 8];
        value_reg <= value_line_reg[QW-1];
    end

    assign done       = done_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign value      = value_reg;

endmodule

// ----- hdl/rhc_div_pipe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_div_pipe: pipelined restoring divider
// One quotient bit per register stage. The dividend is given as a partial
// remainder (below the divisor) and the low bits shifted in MSB first.
// ----------------------------------------------------------------------------
module rhc_div_pipe #(
    parameter int unsigned QW = 12,
    parameter int unsigned DW = 11
) (
    input  logic          clk,
    input  logic [DW-1:0] rem_init,
    input  logic [QW-1:0] low,
    input  logic [DW-1:0] divisor,
    output logic [QW-1:0] quotient
);

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [DW-1:0] div_reg [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic [DW-1:0] rem_in;
            logic [DW-1:0] div_in;
            logic [QW-1:0] low_in;
            logic [QW-1:0] quo_in;
            logic [DW:0]   trial;
            logic [DW:0]   diff;
            logic          ge;
            logic [DW-1:0] rem_next;
            logic [QW-1:0] quo_next;

            if (k == 0) begin : g_first
                assign rem_in = rem_init;
                assign div_in = divisor;
                assign low_in = low;
                assign quo_in = '0;
            end else begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign div_in = div_reg[k-1];
                assign low_in = low_reg[k-1];
                assign quo_in = quo_reg[k-1];
            end

            // shift in the next dividend bit, subtract when it fits
            assign trial    = {rem_in, low_in[QW-1]};
            assign diff     = trial - {1'b0, div_in};
            assign ge       = (trial >= {1'b0, div_in});
            assign rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            assign quo_next = {quo_in[QW-2:0], ge};

            always_ff @(posedge clk)
            begin
                rem_reg[k] <= rem_next;
                low_reg[k] <= {low_in[QW-2:0], 1'b0};
                quo_reg[k] <= quo_next;
                div_reg[k] <= div_in;
            end
        end
    endgenerate

    assign quotient = quo_reg[QW-1];

endmodule

// ----- hdl/rhc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_checker: port-level checks of the RGB to HSV converter
// Busy staying low, latency, one-for-one transfers and gray/black result consistency.
// ----------------------------------------------------------------------------
module rhc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [11:0] hue,
    input logic [7:0]  saturation,
    input logic [7:0]  value
);

    localparam int unsigned LAT = rhc_pkg::LATENCY;

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised on a pipeline that never stalls");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted pixel produced no result at the fixed latency");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching accepted pixel");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (done && value == 8'd0) |-> (saturation == 8'd0))
        else $error("black pixel with nonzero saturation");

    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturation == 8'd0) |-> (hue == 12'd0))
        else $error("unsaturated pixel with nonzero hue");

endmodule

bind rgb_to_hsv_converter_core rhc_checker u_rhc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .hue        (hue),
    .saturation (saturation),
    .value      (value)
);
